// ----- rtl/core/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants for the masked byte pattern search
// Beat layouts for both channels, configuration register map and the
// configuration bundle passed from the register block to the match stage.
// ----------------------------------------------------------------------------
package mbps_pkg;

  // Fixed field widths
  localparam int ADDR_W    = 48;
  localparam int DATA_W    = 8;
  localparam int CFG_W     = 64;
  localparam int LEN_W     = 5;
  localparam int MASK_W    = 16;
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 2;

  // Register indexes (byte address = 8 * index)
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WILDCARD_MASK  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd3;

  // Input beat
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              region_start;
    logic              new_search;
    logic              last_byte;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_beat_t;

  // Configuration bundle
  typedef struct packed {
    logic [CFG_W-1:0]  pattern_low;
    logic [CFG_W-1:0]  pattern_high;
    logic [MASK_W-1:0] wildcard_mask;
    logic [LEN_W-1:0]  pattern_length;
  } cfg_t;

endpackage

// ----- rtl/core/mbps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mbps_cfg_regs: configuration register block
// APB-style slave holding the pattern, wildcard mask and pattern length.
// Registers sit at 8-byte strides; pready is tied high.
// ----------------------------------------------------------------------------
module mbps_cfg_regs
  import mbps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [CFG_W-1:0]   cfg_pwdata,
  output logic [CFG_W-1:0]   cfg_prdata,
  output logic               cfg_pready,
  output cfg_t               cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[PADDR_W-1:PADDR_W-REG_IDX_W];

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_PATTERN_LOW:    cfg_nxt.pattern_low    = cfg_pwdata;
        REG_PATTERN_HIGH:   cfg_nxt.pattern_high   = cfg_pwdata;
        REG_WILDCARD_MASK:  cfg_nxt.wildcard_mask  = cfg_pwdata[MASK_W-1:0];
        REG_PATTERN_LENGTH: cfg_nxt.pattern_length = cfg_pwdata[LEN_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.wildcard_mask  <= '0;
      cfg_r.pattern_length <= LEN_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux, zero-extended
  always_comb begin
    case (reg_idx)
      REG_PATTERN_LOW:    cfg_prdata = cfg_r.pattern_low;
      REG_PATTERN_HIGH:   cfg_prdata = cfg_r.pattern_high;
      REG_WILDCARD_MASK:  cfg_prdata = CFG_W'(cfg_r.wildcard_mask);
      REG_PATTERN_LENGTH: cfg_prdata = CFG_W'(cfg_r.pattern_length);
      default:            cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/mbps_match.sv -----
// ----------------------------------------------------------------------------
// mbps_match: byte window and parallel pattern compare
// Shifts one byte per fire into the window, compares the newest bytes
// against the pattern and decides whether this beat produces a result.
// ----------------------------------------------------------------------------
module mbps_match
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int ADDRESS_BITS      = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_beat_t  beat,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_beat_t res
);

  localparam int CW        = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int WRAP_BITS = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] WRAP_MASK = {ADDR_W{1'b1}} >> (ADDR_W - WRAP_BITS);

  logic [DATA_W-1:0]          win_r   [MAX_PATTERN_BYTES];
  logic [DATA_W-1:0]          win_nxt [MAX_PATTERN_BYTES];
  logic [CW-1:0]              cnt_r, cnt_nxt, cnt_base;
  logic                       found_r, found_nxt, found_eff;
  logic [CW-1:0]              len_eff;
  logic [CW-1:0]              len_m1;
  logic [2*CFG_W-1:0]         pat_all;
  logic [MAX_PATTERN_BYTES-1:0] byte_ok;
  logic                       match;
  logic [ADDR_W-1:0]          addr_diff;

  // Effective length: zero reads as one, saturate at window depth
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len_eff = CW'(1);
    end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN_BYTES)) begin
      len_eff = CW'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = cfg.pattern_length[CW-1:0];
    end
  end
  assign len_m1 = len_eff - CW'(1);

  // Window shift; entry 0 is the newest byte
  always_comb begin
    win_nxt[0] = beat.data_byte;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  // Fill count, emptied on region or search start, saturating
  always_comb begin
    cnt_base = (beat.region_start || beat.new_search) ? '0 : cnt_r;
    cnt_nxt  = (cnt_base < CW'(MAX_PATTERN_BYTES)) ? cnt_base + CW'(1) : cnt_base;
  end

  // Per-position compare: pattern byte i lines up with window entry len-1-i
  assign pat_all = {cfg.pattern_high, cfg.pattern_low};
  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      logic [DATA_W-1:0] sel;
      sel = '0;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
        if (CW'(j) == CW'(len_m1 - CW'(i))) begin
          sel = win_nxt[j];
        end
      end
      byte_ok[i] = cfg.wildcard_mask[i] || (CW'(i) >= len_eff) ||
                   (sel == pat_all[DATA_W*i +: DATA_W]);
    end
  end
  assign match = (cnt_nxt >= len_eff) && (&byte_ok);

  // Result decision
  assign addr_diff = (beat.byte_address - {{(ADDR_W-CW){1'b0}}, len_m1}) & WRAP_MASK;
  always_comb begin
    found_eff     = beat.new_search ? 1'b0 : found_r;
    res_valid     = 1'b0;
    res.found     = 1'b0;
    res.match_address = '0;
    found_nxt     = found_eff;
    if (fire && !found_eff) begin
      if (match) begin
        res_valid         = 1'b1;
        res.found         = 1'b1;
        res.match_address = addr_diff;
        found_nxt         = 1'b1;
      end else if (beat.last_byte) begin
        res_valid = 1'b1;
        found_nxt = 1'b1;
      end
    end
  end

  // Window payload
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
        win_r[j] <= win_nxt[j];
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (fire) begin
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
    end
  end

`ifndef SYNTHESIS
  // Fill count stays within the window depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_PATTERN_BYTES))
    else $error("window fill count beyond depth");

  // A result always closes the search
  a_res_closes: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> found_r)
    else $error("search not closed after result");

  // Not-found results only on the last byte, with a zero address
  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.found) |-> (beat.last_byte && res.match_address == '0))
    else $error("not-found result without last byte");

  // Closed search stays quiet until a new search
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && !beat.new_search) |-> !res_valid)
    else $error("result after search closed");
`endif

endmodule

// ----- rtl/core/masked_byte_pattern_search.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_search: wildcard byte signature scan
// Input register, window compare stage and result register with stall.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one memory byte per
//   beat with its address and region_start, new_search and last_byte flags.
//   Result channel (out_valid / out_stall / out_data) carries at most one beat
//   per search: found = 1 with the address of the first pattern byte, or
//   found = 0 with address zero when last_byte arrives without a match.
//   Configuration (cfg_*) is an APB-style port; registers sit at 8*index:
//   pattern_low, pattern_high, wildcard_mask, pattern_length. Write it only
//   while no beat is in flight.
//   Throughput: one byte per cycle unless a held result stalls the input,
//   set by the combinational window compare. A byte passes the input
//   register and the window compare; its result goes to the result register.
//   Stall: out_stall holds the result register; an empty input register
//   still takes one more byte, then in_stall rises until the result leaves.
//   Reset (rst_n low, synchronous) empties both stages, clears the window
//   count and found mark, and sets pattern_length to 1, other registers to 0.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int ADDRESS_BITS      = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  in_beat_t           in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output out_beat_t          out_data,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [CFG_W-1:0]   cfg_pwdata,
  output logic [CFG_W-1:0]   cfg_prdata,
  output logic               cfg_pready
);

  cfg_t      cfg;
  in_beat_t  s1_r;
  logic      s1_v_r, s1_v_nxt;
  logic      out_v_r, out_v_nxt;
  out_beat_t out_r;
  logic      advance, fire, accept;
  logic      res_valid;
  out_beat_t res;

  mbps_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Handshake control
  assign advance  = !out_v_r || !out_stall;
  assign fire     = s1_v_r && advance;
  assign in_stall = s1_v_r && !advance;
  assign accept   = in_valid && !in_stall;

  mbps_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .ADDRESS_BITS      (ADDRESS_BITS)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .beat      (s1_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Stage valid next values
  always_comb begin
    s1_v_nxt = accept ? 1'b1 : (fire ? 1'b0 : s1_v_r);
    if (fire && res_valid) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_data;
    end
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Input only stalls while the input register is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with empty input register");

  // A stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall) |-> !fire)
    else $error("stage fired into stalled result");

  // An accepted beat occupies the input register next cycle
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted beat lost");
`endif

endmodule

// ----- test/tb_masked_byte_pattern_search.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_search: self-checking bench for the byte pattern scan
// Streams memory bytes through the input channel and predicts each search
// report from a shadow of the pattern registers and a local copy of the byte
// window. Reports are checked in order against the queue of predicted ones.
// Covers directed corner cases, random searches with planted patterns (some
// broken), noise beats, random idling on both sides and a long receiver hold.
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_search;
  import mbps_pkg::*;

  localparam int WINDOW_DEPTH = 16;

  // DUT signals
  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_beat_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_beat_t          out_data;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [CFG_W-1:0]   cfg_pwdata;
  logic [CFG_W-1:0]   cfg_prdata;
  logic               cfg_pready;

  // Shadow of the configuration registers
  logic [CFG_W-1:0]  pat_lo  = '0;
  logic [CFG_W-1:0]  pat_hi  = '0;
  logic [MASK_W-1:0] wc_mask = '0;
  logic [LEN_W-1:0]  pat_len = LEN_W'(1);

  // Predicted scan state
  logic [DATA_W-1:0] win [WINDOW_DEPTH];
  int unsigned       win_fill    = 0;
  bit                search_done = 1'b0;

  // Reports predicted but not yet seen on the result channel
  out_beat_t pending_reports [$];

  int          bytes_sent       = 0;
  int          fail_count       = 0;
  int unsigned send_idle_pct    = 0;
  int unsigned recv_idle_pct    = 0;
  int          long_hold_cycles = 0;
  int          hold_left        = 0;

  masked_byte_pattern_search dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb_masked_byte_pattern_search: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // length 0 acts as 1, anything past the window saturates
  function automatic int unsigned active_len();
    if (pat_len == '0) return 1;
    if (pat_len > LEN_W'(WINDOW_DEPTH)) return WINDOW_DEPTH;
    return 32'(pat_len);
  endfunction

  function automatic logic [DATA_W-1:0] pattern_byte_at(input int unsigned i);
    if (i < 8) return pat_lo[8*i +: 8];
    return pat_hi[8*(i-8) +: 8];
  endfunction

  // Advance the window by one accepted beat and queue any report it causes
  function automatic void scan_byte(input in_beat_t b);
    int unsigned len;
    int          k;
    bit          hit;
    out_beat_t   r;
    len = active_len();
    if (b.new_search) search_done = 1'b0;
    if (b.new_search || b.region_start) begin
      for (k = 0; k < WINDOW_DEPTH; k++) win[k] = '0;
      win_fill = 0;
    end
    for (k = WINDOW_DEPTH - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = b.data_byte;
    if (win_fill < WINDOW_DEPTH) win_fill++;
    if (search_done) return;
    // pattern byte 0 lines up with the oldest byte of the match
    hit = (win_fill >= len);
    for (k = 0; k < int'(len); k++) begin
      if (!wc_mask[k] && win[len-1-k] != pattern_byte_at(k)) hit = 1'b0;
    end
    if (hit) begin
      search_done     = 1'b1;
      r.found         = 1'b1;
      r.match_address = b.byte_address - ADDR_W'(len - 1);
      pending_reports.push_back(r);
    end else if (b.last_byte) begin
      search_done = 1'b1;
      r           = '0;
      pending_reports.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall generation and checking
  // ---------------------------------------------------------------------------

  // Random stall, or a long hold when a test asks for one
  always @(posedge clk) begin
    if (long_hold_cycles > 0) begin
      hold_left        = long_hold_cycles;
      long_hold_cycles = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result beat: found %0d match_address 0x%012h",
               out_data.found, out_data.match_address);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_data.found);
          fail_count++;
        end
        if (out_data.match_address !== want.match_address) begin
          $error("match_address: expected 0x%012h, got 0x%012h",
                 want.match_address, out_data.match_address);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic in_beat_t beat(input logic [DATA_W-1:0] data,
                                    input logic [ADDR_W-1:0] addr,
                                    input logic rs, input logic ns, input logic last);
    in_beat_t b;
    b.data_byte    = data;
    b.byte_address = addr;
    b.region_start = rs;
    b.new_search   = ns;
    b.last_byte    = last;
    return b;
  endfunction

  // Offer one beat and return at the edge that accepts it; valid stays high so
  // the next call can follow back to back
  task automatic send_byte(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_byte(b);
    bytes_sent++;
  endtask

  // Stop offering, then wait out every report and the pipeline latency
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Two-phase register write; lands at the access edge with pready high
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:    pat_lo  = value;
      REG_PATTERN_HIGH:   pat_hi  = value;
      REG_WILDCARD_MASK:  wc_mask = value[MASK_W-1:0];
      REG_PATTERN_LENGTH: pat_len = value[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_pattern(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                             input logic [MASK_W-1:0] mask, input logic [LEN_W-1:0] len);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_WILDCARD_MASK, CFG_W'(mask));
    write_reg(REG_PATTERN_LENGTH, CFG_W'(len));
  endtask

  task automatic random_pattern();
    logic [MASK_W-1:0] mask;
    logic [LEN_W-1:0]  len;
    case ($urandom_range(9))
      0:       mask = '0;
      1:       mask = '1;
      default: mask = MASK_W'($urandom & $urandom);
    endcase
    case ($urandom_range(9))
      0:       len = LEN_W'($urandom_range(31));
      1:       len = LEN_W'(WINDOW_DEPTH);
      2:       len = LEN_W'(1);
      default: len = LEN_W'($urandom_range(2, 8));
    endcase
    set_pattern({$urandom, $urandom}, {$urandom, $urandom}, mask, len);
  endtask

  // One search: new_search on the first beat, usually a planted pattern,
  // scattered region starts, last_byte at the end unless the search is broken
  task automatic run_search();
    int                n;
    int                at;
    int unsigned       len;
    bit                plant;
    bit                broken;
    logic [ADDR_W-1:0] base;
    logic [DATA_W-1:0] data;
    n      = $urandom_range(4, 40);
    len    = active_len();
    plant  = ($urandom_range(9) < 7);
    broken = ($urandom_range(9) == 0);
    at     = $urandom_range(0, n - 1);
    base   = ADDR_W'({$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      data = DATA_W'($urandom);
      if (plant && i >= at && i < at + int'(len) && !wc_mask[i-at])
        data = pattern_byte_at(i - at);
      send_byte(beat(data, base + ADDR_W'(i),
                     (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(40) == 0),
                     (i == 0) || (broken && $urandom_range(7) == 0),
                     (i == n - 1) && !broken));
    end
  endtask

  // Fully random beats
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_byte(beat(DATA_W'($urandom), ADDR_W'({$urandom, $urandom}),
                     ($urandom_range(3) == 0), ($urandom_range(3) == 0),
                     ($urandom_range(3) == 0)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: one-byte pattern of zero, no wildcards
  task automatic test_reset_defaults();
    send_byte(beat(8'h00, 48'h0, 1'b0, 1'b1, 1'b0));
    // search already finished, last byte gives nothing
    send_byte(beat(8'hFF, 48'h1, 1'b0, 1'b0, 1'b1));
    // not found on a single-byte search
    send_byte(beat(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1));
    drain();
  endtask

  // Full 16-byte pattern matching on the last byte, addresses wrapping
  task automatic test_full_length_wrap();
    logic [ADDR_W-1:0] base;
    base = 48'hFFFF_FFFF_FFF8;
    set_pattern('1, '0, '0, LEN_W'(WINDOW_DEPTH));
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      send_byte(beat((i < 8) ? 8'hFF : 8'h00, base + ADDR_W'(i),
                     1'b0, (i == 0), (i == WINDOW_DEPTH - 1)));
    end
    drain();
  endtask

  // Length zero acts as one; oversize length saturates and needs a full window
  task automatic test_length_limits();
    set_pattern(64'h5A, '0, 16'h0001, LEN_W'(0));
    // both flags on one beat
    send_byte(beat(8'hA5, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1));
    drain();
    set_pattern('0, '1, '1, '1);
    send_byte(beat(8'h11, 48'h100, 1'b0, 1'b1, 1'b0));
    send_byte(beat(8'h22, 48'h101, 1'b0, 1'b0, 1'b0));
    send_byte(beat(8'h33, 48'h102, 1'b1, 1'b0, 1'b0));
    send_byte(beat(8'h44, 48'h103, 1'b0, 1'b0, 1'b1));
    drain();
  endtask

  task automatic test_random_searches(input int n_items);
    int target;
    target = bytes_sent + n_items;
    drain();
    random_pattern();
    while (bytes_sent < target) begin
      if ($urandom_range(3) == 0) begin
        drain();
        random_pattern();
      end
      if ($urandom_range(9) == 0) send_noise();
      else run_search();
    end
    drain();
  endtask

  // Every beat starts a search that matches at once; a long receiver hold
  // backs results up until the input stalls
  task automatic test_output_backpressure();
    set_pattern('0, '0, 16'h0001, LEN_W'(1));
    long_hold_cycles = 120;
    repeat (40) begin
      send_byte(beat(DATA_W'($urandom), ADDR_W'({$urandom, $urandom}),
                     1'b0, 1'b1, 1'($urandom_range(1))));
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    foreach (win[k]) win[k] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 63;
    test_reset_defaults();
    test_full_length_wrap();
    test_length_limits();
    test_random_searches(470);

    send_idle_pct = 63;
    recv_idle_pct = 28;
    test_random_searches(470);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_searches(470);
    test_output_backpressure();

    drain();
    if (fail_count == 0) begin
      $display("tb_masked_byte_pattern_search: clean");
    end else begin
      $display("tb_masked_byte_pattern_search: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mbps_pkg.sv
rtl/core/mbps_cfg_regs.sv
rtl/core/mbps_match.sv
rtl/core/masked_byte_pattern_search.sv
test/tb_masked_byte_pattern_search.sv
